// ----- src/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types, constants and helpers of the INI line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilt_pkg;

  localparam int LINE_MAX_DEF    = 64;
  localparam int SECTION_MAX_DEF = 65;
  localparam int RESULT_CAP      = 26;
  localparam int LEN_FW          = 11;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic PART_KEY   = 1'b0;
  localparam logic PART_VALUE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [LEN_FW-1:0] len;
    logic              ovf;
  } cmd_t;

  typedef struct packed {
    logic        part_kind;
    logic [63:0] chunk_bytes;
    logic [3:0]  byte_count;
    logic        line_truncated;
    logic        last_of_pair;
  } out_item_t;

  function automatic logic [7:0] glob_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h4C;
      3'd2:    c = 8'h4F;
      3'd3:    c = 8'h42;
      3'd4:    c = 8'h41;
      3'd5:    c = 8'h4C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

// ----- src/ilt_front.sv -----
// ----------------------------------------------------------------------------
// ilt_front
// Takes text bytes, fills the line buffer and hands finished lines onward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilt_front #(
  parameter int LINE_MAX = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [7:0]                  text_byte,
  input  wire logic                        end_of_file,
  output logic                             full,
  input  wire logic                        busy,
  input  wire logic                        cmd_take,
  output ilt_pkg::cmd_t                    cmd,
  output logic                             lw_en,
  output logic [$clog2(LINE_MAX)-1:0]      lw_addr,
  output logic [7:0]                       lw_data
);
  import ilt_pkg::*;

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int LA = $clog2(LINE_MAX);

  logic [LW-1:0] len;
  logic          ovf;
  logic          acc;
  logic          room;
  logic [LW-1:0] len_after;
  logic          ovf_after;

  assign full      = cmd.valid || busy;
  assign acc       = push && !full;
  assign room      = int'(len) < LINE_MAX;
  assign lw_en     = acc && (text_byte != CH_NL) && room;
  assign lw_addr   = LA'(len);
  assign lw_data   = text_byte;
  assign len_after = lw_en ? len + 1'b1 : len;
  assign ovf_after = ovf || (acc && (text_byte != CH_NL) && !room);

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ovf       <= 1'b0;
      cmd.valid <= 1'b0;
      cmd.len   <= '0;
      cmd.ovf   <= 1'b0;
    end else begin
      if (cmd_take) begin
        cmd.valid <= 1'b0;
      end
      if (acc) begin
        if (text_byte == CH_NL || end_of_file) begin
          cmd.valid <= 1'b1;
          cmd.len   <= LEN_FW'(len_after);
          cmd.ovf   <= ovf_after;
          len       <= '0;
          ovf       <= 1'b0;
        end else begin
          len <= len_after;
          ovf <= ovf_after;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/ilt_back.sv -----
// ----------------------------------------------------------------------------
// ilt_back
// Walks a buffered line: trims, classifies, normalizes names, emits chunks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilt_back #(
  parameter int LINE_MAX    = 64,
  parameter int SECTION_MAX = 65
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ilt_pkg::cmd_t               cmd,
  output logic                             cmd_take,
  output logic                             busy,
  input  wire logic                        lw_en,
  input  wire logic [$clog2(LINE_MAX)-1:0] lw_addr,
  input  wire logic [7:0]                  lw_data,
  output logic                             oq_push,
  output ilt_pkg::out_item_t               oq_item,
  input  wire logic                        oq_full
);
  import ilt_pkg::*;

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int LA = $clog2(LINE_MAX);
  localparam int ND = LINE_MAX + 2;
  localparam int NA = $clog2(ND);
  localparam int NW = $clog2(LINE_MAX + 3);
  localparam int SA = $clog2(SECTION_MAX);
  localparam int SLW = $clog2(SECTION_MAX + 1);
  localparam int PW = $clog2(SECTION_MAX + LINE_MAX + 3);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_TRIM_L    = 4'd1;
  localparam logic [3:0] S_TRIM_R    = 4'd2;
  localparam logic [3:0] S_CLASS     = 4'd3;
  localparam logic [3:0] S_SEC_BR    = 4'd4;
  localparam logic [3:0] S_SEC_TL    = 4'd5;
  localparam logic [3:0] S_SEC_TR    = 4'd6;
  localparam logic [3:0] S_FIND_EQ   = 4'd7;
  localparam logic [3:0] S_KE_TRIM   = 4'd8;
  localparam logic [3:0] S_VS_TRIM   = 4'd9;
  localparam logic [3:0] S_NORM      = 4'd10;
  localparam logic [3:0] S_KEY       = 4'd11;
  localparam logic [3:0] S_VAL_START = 4'd12;
  localparam logic [3:0] S_VAL       = 4'd13;
  localparam logic [3:0] S_PUSH      = 4'd14;

  logic [7:0] line_mem [LINE_MAX];
  logic [7:0] sec_mem  [SECTION_MAX];
  logic [7:0] name_mem [ND];
  logic [7:0] line_rd, sec_rd, name_rd;
  logic [LA-1:0] line_ra;
  logic [SA-1:0] sec_ra;
  logic [NA-1:0] name_ra;

  logic [3:0]    state, ret;
  logic          ph;
  logic [LW-1:0] s, e, eq, ke, vs, vp, nend;
  logic          ovf;
  logic          tgt;
  logic [NW-1:0] nlen, key_len;
  logic [7:0]    pend;
  logic          prev_dot, prev_us;
  logic          dot_found, dot_pfound;
  logic [NW-1:0] dot_last, dot_plast;
  logic          global_sec;
  logic [SLW-1:0] sec_len;
  logic [PW-1:0] p;
  logic [63:0]   chunk;
  logic [3:0]    cnt;
  logic          kind, last_flag;
  logic [4:0]    res_cnt;

  // normalizer step
  logic          wr_en;
  logic [NW-1:0] wr_idx;
  logic [7:0]    wr_dat;
  logic [NW-1:0] nlen_next, dot_last_next, dot_plast_next;
  logic [7:0]    pend_next;
  logic          prev_dot_next, prev_us_next, dot_found_next, dot_pfound_next;
  logic          flushing;

  logic [PW-1:0] ktot, nidx;
  logic [7:0]    kbyte;
  logic          out_last;

  assign busy     = state != S_IDLE;
  assign cmd_take = (state == S_IDLE) && cmd.valid;
  assign flushing = !(s < nend);

  always_comb begin
    case (state)
      S_TRIM_R, S_SEC_BR, S_SEC_TR: line_ra = LA'(e - 1'b1);
      S_FIND_EQ:                    line_ra = LA'(eq);
      S_KE_TRIM:                    line_ra = LA'(ke - 1'b1);
      S_VS_TRIM:                    line_ra = LA'(vs);
      S_VAL:                        line_ra = LA'(vp);
      default:                      line_ra = LA'(s);
    endcase
  end

  assign ktot    = PW'(sec_len) + PW'(key_len) + 1'b1;
  assign nidx    = p - PW'(sec_len) - 1'b1;
  assign sec_ra  = SA'(p);
  assign name_ra = NA'(nidx);

  always_comb begin
    if (p < PW'(sec_len)) begin
      kbyte = global_sec ? glob_char(p[2:0]) : sec_rd;
    end else if (p == PW'(sec_len)) begin
      kbyte = dot_found ? CH_DOT : CH_BANG;
    end else if (dot_found && PW'(dot_last) == nidx) begin
      kbyte = CH_BANG;
    end else begin
      kbyte = name_rd;
    end
  end

  always_comb begin
    wr_en           = 1'b0;
    wr_idx          = nlen - 1'b1;
    wr_dat          = pend;
    nlen_next       = nlen;
    pend_next       = pend;
    prev_dot_next   = prev_dot;
    prev_us_next    = prev_us;
    dot_found_next  = dot_found;
    dot_last_next   = dot_last;
    dot_pfound_next = dot_pfound;
    dot_plast_next  = dot_plast;
    if (flushing) begin
      wr_en = nlen != '0;
    end else if (prev_dot && is_digit(line_rd)) begin
      wr_en         = 1'b1;
      wr_dat        = CH_UNDER;
      pend_next     = line_rd;
      prev_dot_next = 1'b0;
      prev_us_next  = 1'b0;
      if (nlen != '0) begin
        nlen_next      = nlen + 1'b1;
        dot_found_next = dot_pfound;
        dot_last_next  = dot_plast;
      end else begin
        wr_idx    = '0;
        nlen_next = NW'(2);
      end
    end else if (is_alnum(line_rd)) begin
      wr_en         = nlen != '0;
      pend_next     = line_rd;
      nlen_next     = nlen + 1'b1;
      prev_dot_next = 1'b0;
      prev_us_next  = 1'b0;
    end else if (is_space(line_rd) || line_rd == CH_UNDER) begin
      if (!prev_us) begin
        wr_en         = nlen != '0;
        pend_next     = CH_UNDER;
        nlen_next     = nlen + 1'b1;
        prev_dot_next = 1'b0;
        prev_us_next  = 1'b1;
      end
    end else if (!prev_dot) begin
      wr_en           = nlen != '0;
      pend_next       = CH_DOT;
      nlen_next       = nlen + 1'b1;
      prev_dot_next   = 1'b1;
      prev_us_next    = 1'b0;
      dot_pfound_next = dot_found;
      dot_plast_next  = dot_last;
      dot_found_next  = 1'b1;
      dot_last_next   = nlen;
    end
  end

  logic norm_wr;
  assign norm_wr = (state == S_NORM) && (flushing ? !ph : ph) && wr_en;

  always_ff @(posedge clk) begin
    if (lw_en) begin
      line_mem[lw_addr] <= lw_data;
    end
    if (norm_wr && !tgt && int'(wr_idx) < SECTION_MAX) begin
      sec_mem[SA'(wr_idx)] <= wr_dat;
    end
    if (norm_wr && tgt) begin
      name_mem[NA'(wr_idx)] <= wr_dat;
    end
    line_rd <= line_mem[line_ra];
    sec_rd  <= sec_mem[sec_ra];
    name_rd <= name_mem[name_ra];
  end

  assign out_last = last_flag || (int'(res_cnt) == RESULT_CAP - 1);
  assign oq_push  = (state == S_PUSH) && !oq_full;

  always_comb begin
    oq_item.part_kind      = kind;
    oq_item.chunk_bytes    = chunk;
    oq_item.byte_count     = cnt;
    oq_item.line_truncated = ovf;
    oq_item.last_of_pair   = out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph         <= 1'b0;
      global_sec <= 1'b1;
      sec_len    <= SLW'(6);
    end else begin
      unique case (state)
        S_IDLE: begin
          ph <= 1'b0;
          if (cmd.valid) begin
            s     <= '0;
            e     <= LW'(cmd.len);
            ovf   <= cmd.ovf;
            state <= S_TRIM_L;
          end
        end
        S_TRIM_L: begin
          if (!(s < e)) begin
            state <= S_IDLE;
          end else begin
            ph <= !ph;
            if (ph) begin
              if (line_rd <= CH_SPACE) s <= s + 1'b1;
              else state <= S_TRIM_R;
            end
          end
        end
        S_TRIM_R: begin
          ph <= !ph;
          if (ph) begin
            if (line_rd <= CH_SPACE) e <= e - 1'b1;
            else state <= S_CLASS;
          end
        end
        S_CLASS: begin
          ph <= !ph;
          if (ph) begin
            if (line_rd == CH_SLASH || line_rd == CH_SEMI || line_rd == CH_HASH) begin
              state <= S_IDLE;
            end else if (line_rd == CH_LBRK) begin
              state <= S_SEC_BR;
            end else begin
              eq    <= s;
              state <= S_FIND_EQ;
            end
          end
        end
        S_SEC_BR: begin
          ph <= !ph;
          if (ph) begin
            if (line_rd == CH_RBRK && (e - s) >= LW'(2)) e <= e - 1'b1;
            s     <= s + 1'b1;
            state <= S_SEC_TL;
          end
        end
        S_SEC_TL: begin
          if (!(s < e)) begin
            tgt <= 1'b0; nend <= e; nlen <= '0;
            prev_dot <= 1'b1; prev_us <= 1'b0; dot_found <= 1'b0; dot_pfound <= 1'b0;
            state <= S_NORM;
          end else begin
            ph <= !ph;
            if (ph) begin
              if (line_rd <= CH_SPACE) s <= s + 1'b1;
              else state <= S_SEC_TR;
            end
          end
        end
        S_SEC_TR: begin
          ph <= !ph;
          if (ph) begin
            if (line_rd <= CH_SPACE) begin
              e <= e - 1'b1;
            end else begin
              tgt <= 1'b0; nend <= e; nlen <= '0;
              prev_dot <= 1'b1; prev_us <= 1'b0; dot_found <= 1'b0; dot_pfound <= 1'b0;
              state <= S_NORM;
            end
          end
        end
        S_FIND_EQ: begin
          if (!(eq < e)) begin
            state <= S_IDLE;
          end else begin
            ph <= !ph;
            if (ph) begin
              if (line_rd == CH_EQ) begin
                ke    <= eq;
                vs    <= eq + 1'b1;
                state <= S_KE_TRIM;
              end else begin
                eq <= eq + 1'b1;
              end
            end
          end
        end
        S_KE_TRIM: begin
          if (!(s < ke)) begin
            state <= S_VS_TRIM;
          end else begin
            ph <= !ph;
            if (ph) begin
              if (line_rd <= CH_SPACE) ke <= ke - 1'b1;
              else state <= S_VS_TRIM;
            end
          end
        end
        S_VS_TRIM: begin
          if (!(vs < e)) begin
            tgt <= 1'b1; nend <= ke; nlen <= '0;
            prev_dot <= 1'b1; prev_us <= 1'b0; dot_found <= 1'b0; dot_pfound <= 1'b0;
            state <= S_NORM;
          end else begin
            ph <= !ph;
            if (ph) begin
              if (line_rd <= CH_SPACE) begin
                vs <= vs + 1'b1;
              end else begin
                tgt <= 1'b1; nend <= ke; nlen <= '0;
                prev_dot <= 1'b1; prev_us <= 1'b0; dot_found <= 1'b0; dot_pfound <= 1'b0;
                state <= S_NORM;
              end
            end
          end
        end
        S_NORM: begin
          if (flushing) begin
            ph <= 1'b0;
            if (!tgt) begin
              if (nlen == '0) begin
                global_sec <= 1'b1;
                sec_len    <= SLW'(6);
              end else begin
                global_sec <= 1'b0;
                sec_len    <= (int'(nlen) > SECTION_MAX) ? SLW'(SECTION_MAX) : SLW'(nlen);
              end
              state <= S_IDLE;
            end else begin
              key_len   <= nlen;
              p         <= '0;
              kind      <= PART_KEY;
              chunk     <= '0;
              cnt       <= '0;
              res_cnt   <= '0;
              last_flag <= 1'b0;
              state     <= S_KEY;
            end
          end else begin
            ph <= !ph;
            if (ph) begin
              s          <= s + 1'b1;
              nlen       <= nlen_next;
              pend       <= pend_next;
              prev_dot   <= prev_dot_next;
              prev_us    <= prev_us_next;
              dot_found  <= dot_found_next;
              dot_last   <= dot_last_next;
              dot_pfound <= dot_pfound_next;
              dot_plast  <= dot_plast_next;
            end
          end
        end
        S_KEY: begin
          ph <= !ph;
          if (ph) begin
            chunk[cnt[2:0]*8 +: 8] <= kbyte;
            cnt <= cnt + 1'b1;
            p   <= p + 1'b1;
            if (p == ktot - 1'b1) begin
              ret   <= S_VAL_START;
              state <= S_PUSH;
            end else if (cnt == 4'd7) begin
              ret   <= S_KEY;
              state <= S_PUSH;
            end
          end
        end
        S_VAL_START: begin
          ph   <= 1'b0;
          vp   <= vs;
          kind <= PART_VALUE;
          if (!(vs < e)) begin
            last_flag <= 1'b1;
            state     <= S_PUSH;
          end else begin
            state <= S_VAL;
          end
        end
        S_VAL: begin
          ph <= !ph;
          if (ph) begin
            chunk[cnt[2:0]*8 +: 8] <= line_rd;
            cnt <= cnt + 1'b1;
            vp  <= vp + 1'b1;
            if (vp + 1'b1 == e) begin
              last_flag <= 1'b1;
              state     <= S_PUSH;
            end else if (cnt == 4'd7) begin
              ret   <= S_VAL;
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          ph <= 1'b0;
          if (!oq_full) begin
            chunk   <= '0;
            cnt     <= '0;
            res_cnt <= res_cnt + 1'b1;
            state   <= out_last ? S_IDLE : ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/ilt_outq.sv -----
// ----------------------------------------------------------------------------
// ilt_outq
// Two-entry result queue between the line walker and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilt_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire ilt_pkg::out_item_t wdata,
  output logic                    oq_full,
  input  wire logic               pop,
  output logic                    empty,
  output ilt_pkg::out_item_t      head
);
  import ilt_pkg::*;

  out_item_t  slot [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       do_pop;

  assign oq_full = fill == 2'd2;
  assign empty   = fill == 2'd0;
  assign head    = slot[rp];
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wp] <= wdata;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= '0;
    end else begin
      if (wr) wp <= !wp;
      if (do_pop) rp <= !rp;
      fill <= fill + {1'b0, wr} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ----- src/ini_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// ini_line_tokenizer
// Buffers INI text one line at a time and emits section.key / value chunks.
// ----------------------------------------------------------------------------
// Flow: a line end, or a byte pushed with end_of_file, hands the buffered line
// to the walker, which scans it and pushes its chunks into the result queue.
// Throughput: one byte per cycle within a line while full is low; full stays
// high while a finished line waits or the line walker is busy.
// Reset: synchronous rst empties the line and result queue and sets the
// section to GLOBAL; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ini_line_tokenizer #(
  parameter int LINE_MAX    = ilt_pkg::LINE_MAX_DEF,
  parameter int SECTION_MAX = ilt_pkg::SECTION_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_file,
  output logic             empty,
  input  wire logic        pop,
  output logic             part_kind,
  output logic [63:0]      chunk_bytes,
  output logic [3:0]       byte_count,
  output logic             line_truncated,
  output logic             last_of_pair
);
  import ilt_pkg::*;

  cmd_t                        cmd;
  logic                        cmd_take, busy;
  logic                        lw_en;
  logic [$clog2(LINE_MAX)-1:0] lw_addr;
  logic [7:0]                  lw_data;
  logic                        oq_push, oq_full;
  out_item_t                   oq_item, head;

  ilt_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk, .rst, .push, .text_byte, .end_of_file, .full,
    .busy, .cmd_take, .cmd, .lw_en, .lw_addr, .lw_data
  );

  ilt_back #(.LINE_MAX(LINE_MAX), .SECTION_MAX(SECTION_MAX)) u_back (
    .clk, .rst, .cmd, .cmd_take, .busy, .lw_en, .lw_addr, .lw_data,
    .oq_push, .oq_item, .oq_full
  );

  ilt_outq u_outq (
    .clk, .rst, .wr(oq_push), .wdata(oq_item), .oq_full, .pop, .empty, .head
  );

  assign part_kind      = head.part_kind;
  assign chunk_bytes    = head.chunk_bytes;
  assign byte_count     = head.byte_count;
  assign line_truncated = head.line_truncated;
  assign last_of_pair   = head.last_of_pair;

  a_busy_full: assert property (@(posedge clk) disable iff (rst) busy |-> full)
    else $error("byte accepted while line walker busy");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) oq_push |-> !oq_full)
    else $error("result queue overrun");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> byte_count <= 4'd8)
    else $error("chunk byte count out of range");
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_count == 4'd0) |-> (part_kind && last_of_pair))
    else $error("empty chunk outside an empty value");

endmodule

`default_nettype wire
